### rtl/rpd_pkg.sv
package rpd_pkg;

   localparam int HEADER_LEN = 128;
   localparam int HC_W       = 8;
   localparam int WORD_W     = 16;
   localparam int GEOM_W     = 17;
   localparam int LEN_W      = 6;
   localparam int CMD_DEPTH  = 2;
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_CNT_W  = 3;

   localparam logic [1:0] RUN_MARK = 2'b11;

   localparam logic [1:0] PLANE_RED   = 2'd0;
   localparam logic [1:0] PLANE_GREEN = 2'd1;
   localparam logic [1:0] PLANE_BLUE  = 2'd2;
   localparam logic [1:0] PLANE_LAST  = 2'd3;

   localparam logic [HC_W-1:0] HDR_XMIN_LO = 8'd4;
   localparam logic [HC_W-1:0] HDR_YMAX_HI = 8'd11;
   localparam logic [HC_W-1:0] HDR_LAST    = 8'd127;

   typedef struct packed {
      logic              geom;
      logic              empty_img;
      logic [7:0]        value;
      logic [LEN_W-1:0]  len;
      logic [GEOM_W-1:0] width;
      logic [GEOM_W-1:0] height;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [9:0]  pixel_column;
      logic [15:0] pixel_row;
      logic        run_last;
   } pix_type;

endpackage

### rtl/rpd_ram.sv
module rpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/rpd_fifo.sv
module rpd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/rpd_front.sv
module rpd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             start_of_file,
   output logic             cmd_push,
   output rpd_pkg::cmd_type cmd_data
);

   logic [rpd_pkg::HC_W-1:0]   hc_ff, hc_in, hc_eff;
   logic [rpd_pkg::WORD_W-1:0] word_ff [4];
   logic [rpd_pkg::WORD_W-1:0] word_in [4];
   logic                       pend_ff, pend_in, pend_eff;
   logic [rpd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [rpd_pkg::HC_W-1:0]   hofs;
   logic [1:0]                 widx;
   logic [rpd_pkg::GEOM_W:0]   wdiff, hdiff;

   assign hc_eff   = start_of_file ? '0 : hc_ff;
   assign pend_eff = start_of_file ? 1'b0 : pend_ff;
   assign hofs     = hc_eff - rpd_pkg::HDR_XMIN_LO;
   assign widx     = hofs[2:1];
   assign wdiff    = {2'b0, word_ff[2]} - {2'b0, word_ff[0]} + 1'b1;
   assign hdiff    = {2'b0, word_ff[3]} - {2'b0, word_ff[1]} + 1'b1;

   always_comb begin
      hc_in    = hc_ff;
      pend_in  = pend_ff;
      len_in   = len_ff;
      cmd_push = 1'b0;
      cmd_data.geom      = 1'b0;
      cmd_data.empty_img = (word_ff[2] < word_ff[0]) || (word_ff[3] < word_ff[1]);
      cmd_data.value     = data_byte;
      cmd_data.len       = rpd_pkg::LEN_W'(1);
      cmd_data.width     = wdiff[rpd_pkg::GEOM_W-1:0];
      cmd_data.height    = hdiff[rpd_pkg::GEOM_W-1:0];
      for (int i = 0; i < 4; i++) begin
         word_in[i] = start_of_file ? '0 : word_ff[i];
      end
      if (accept) begin
         pend_in = pend_eff;
         if (hc_eff < rpd_pkg::HC_W'(rpd_pkg::HEADER_LEN)) begin
            if (hc_eff >= rpd_pkg::HDR_XMIN_LO && hc_eff <= rpd_pkg::HDR_YMAX_HI) begin
               if (hc_eff[0]) begin
                  word_in[widx][15:8] = data_byte;
               end else begin
                  word_in[widx][7:0] = data_byte;
               end
            end
            hc_in = hc_eff + 1'b1;
            if (hc_eff == rpd_pkg::HDR_LAST) begin
               cmd_push      = 1'b1;
               cmd_data.geom = 1'b1;
            end
         end else if (pend_eff) begin
            pend_in      = 1'b0;
            cmd_data.len = len_ff;
            cmd_push     = (len_ff != '0);
         end else if (data_byte[7:6] == rpd_pkg::RUN_MARK) begin
            pend_in = 1'b1;
            len_in  = data_byte[5:0];
         end else begin
            cmd_push = 1'b1;
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            word_in[i] = word_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff   <= '0;
         pend_ff <= 1'b0;
         len_ff  <= '0;
         for (int i = 0; i < 4; i++) begin
            word_ff[i] <= '0;
         end
      end else begin
         hc_ff   <= hc_in;
         pend_ff <= pend_in;
         len_ff  <= len_in;
         for (int i = 0; i < 4; i++) begin
            word_ff[i] <= word_in[i];
         end
      end
   end

endmodule

### rtl/rpd_back.sv
module rpd_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_empty,
   input  rpd_pkg::cmd_type                    cmd_data,
   output logic                                cmd_pop,
   input  logic [rpd_pkg::OUT_CNT_W-1:0]       out_count,
   output logic                                out_push,
   output rpd_pkg::pix_type                    out_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [CW-1:0]                 width_ff, width_in, width_sat;
   logic [rpd_pkg::GEOM_W-1:0]    height_ff, height_in;
   logic [rpd_pkg::GEOM_W-1:0]    row_ff, row_in, row_next;
   logic [AW-1:0]                 col_ff, col_in;
   logic [1:0]                    plane_ff, plane_in;
   logic                          done_ff, done_in;
   logic [rpd_pkg::LEN_W-1:0]     idx_ff, idx_in;
   logic                          rd_pend_ff, rd_pend_in;
   logic [AW-1:0]                 rd_col_ff;
   logic [15:0]                   rd_row_ff;
   logic                          rd_last_ff;
   logic                          step, col_last, px_last, room, rd_en;
   logic [2:0]                    wr_en;
   logic [7:0]                    rdata [3];
   logic [AW+9:0]                 col_ext;

   assign width_sat = (cmd_data.width > rpd_pkg::GEOM_W'(MAX_WIDTH)) ?
                      CW'(MAX_WIDTH) : CW'(cmd_data.width);
   assign col_last  = ((CW+1)'(col_ff) + 1'b1) == (CW+1)'(width_ff);
   assign px_last   = col_last || (idx_ff == cmd_data.len - 1'b1);
   assign row_next  = row_ff + 1'b1;
   assign room      = ({1'b0, out_count} + {{rpd_pkg::OUT_CNT_W{1'b0}}, rd_pend_ff})
                      < (rpd_pkg::OUT_CNT_W+1)'(rpd_pkg::OUT_DEPTH);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      plane_in  = plane_ff;
      done_in   = done_ff;
      idx_in    = idx_ff;
      cmd_pop   = 1'b0;
      step      = 1'b0;
      if (!cmd_empty) begin
         if (cmd_data.geom) begin
            cmd_pop   = 1'b1;
            width_in  = width_sat;
            height_in = cmd_data.height;
            row_in    = '0;
            col_in    = '0;
            plane_in  = rpd_pkg::PLANE_RED;
            idx_in    = '0;
            done_in   = cmd_data.empty_img;
         end else if (done_ff) begin
            cmd_pop = 1'b1;
            idx_in  = '0;
         end else if (plane_ff != rpd_pkg::PLANE_LAST || room) begin
            step    = 1'b1;
            cmd_pop = px_last;
            idx_in  = px_last ? '0 : idx_ff + 1'b1;
            if (col_last) begin
               col_in = '0;
               if (plane_ff == rpd_pkg::PLANE_LAST) begin
                  plane_in = rpd_pkg::PLANE_RED;
                  row_in   = row_next;
                  if (row_next >= height_ff) begin
                     done_in = 1'b1;
                  end
               end else begin
                  plane_in = plane_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   assign wr_en[0]   = step && (plane_ff == rpd_pkg::PLANE_RED);
   assign wr_en[1]   = step && (plane_ff == rpd_pkg::PLANE_GREEN);
   assign wr_en[2]   = step && (plane_ff == rpd_pkg::PLANE_BLUE);
   assign rd_en      = step && (plane_ff == rpd_pkg::PLANE_LAST);
   assign rd_pend_in = rd_en;

   for (genvar p = 0; p < 3; p++) begin : g_plane
      rpd_ram #(
         .WIDTH (8),
         .DEPTH (MAX_WIDTH)
      ) u_store (
         .clock   (clock),
         .wr_en   (wr_en[p]),
         .wr_addr (col_ff),
         .wr_data (cmd_data.value),
         .rd_en   (rd_en),
         .rd_addr (col_ff),
         .rd_data (rdata[p])
      );
   end

   assign col_ext               = {10'b0, rd_col_ff};
   assign out_push              = rd_pend_ff;
   assign out_data.red          = rdata[0];
   assign out_data.green        = rdata[1];
   assign out_data.blue         = rdata[2];
   assign out_data.pixel_column = col_ext[9:0];
   assign out_data.pixel_row    = rd_row_ff;
   assign out_data.run_last     = rd_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= '0;
         height_ff  <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         plane_ff   <= rpd_pkg::PLANE_RED;
         done_ff    <= 1'b1;
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         plane_ff   <= plane_in;
         done_ff    <= done_in;
         idx_ff     <= idx_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_col_ff  <= col_ff;
         rd_row_ff  <= row_ff[15:0];
         rd_last_ff <= px_last;
      end
   end

endmodule

### rtl/pcx_rle_planar_rgb_decoder_core.sv
// PCX run-length decoder for 24-bit planar images. Takes one file byte per
// word; header bytes and literal or run-marker body bytes are taken at one
// per cycle. A run of n pixels makes one line-store access per pixel, one per
// cycle while plane-3 reads find room in the result queue, and push is held
// off by full once the two-entry command queue fills. Planes 0 to 2 are
// written to the line store; each plane-3 pixel reads the store and its RGB
// word is registered and pushed into a four-entry result queue. Line
// width saturates at MAX_WIDTH, which also sets the line store depth.
module pcx_rle_planar_rgb_decoder_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [9:0]  rsp_pixel_column,
   output logic [15:0] rsp_pixel_row,
   output logic        rsp_run_last
);

   rpd_pkg::cmd_type                  cmd_wr, cmd_rd;
   rpd_pkg::pix_type                  pix_wr, pix_rd;
   logic                              cmd_push, cmd_pop, cmd_empty, cmd_full;
   logic                              pix_push;
   logic [rpd_pkg::OUT_CNT_W-1:0]     pix_count;

   assign full = cmd_full;

   rpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (push && !cmd_full),
      .data_byte     (req_data_byte),
      .start_of_file (req_start_of_file),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_wr)
   );

   rpd_fifo #(
      .WIDTH ($bits(rpd_pkg::cmd_type)),
      .DEPTH (rpd_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd),
      .empty     (cmd_empty),
      .full      (cmd_full),
      .count     ()
   );

   rpd_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .out_count (pix_count),
      .out_push  (pix_push),
      .out_data  (pix_wr)
   );

   rpd_fifo #(
      .WIDTH ($bits(rpd_pkg::pix_type)),
      .DEPTH (rpd_pkg::OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (pix_push),
      .push_data (pix_wr),
      .pop       (pop),
      .pop_data  (pix_rd),
      .empty     (empty),
      .full      (),
      .count     (pix_count)
   );

   assign rsp_red          = pix_rd.red;
   assign rsp_green        = pix_rd.green;
   assign rsp_blue         = pix_rd.blue;
   assign rsp_pixel_column = pix_rd.pixel_column;
   assign rsp_pixel_row    = pix_rd.pixel_row;
   assign rsp_run_last     = pix_rd.run_last;

endmodule

### sim/pcx_rle_planar_rgb_decoder_core_test.sv
`timescale 1ns / 100ps

class pcx_pixel_scoreboard;
   localparam int STORE_DEPTH = 1024;

   int unsigned hdr_count;
   logic [15:0] hdr_word [4];
   int unsigned col_pos;
   logic [1:0]  plane;
   int unsigned row_pos;
   bit          run_pend;
   logic [5:0]  run_len;
   bit          done;
   logic [23:0] line_rgb [STORE_DEPTH];
   rpd_pkg::pix_type pending_pixels [$];
   int          errors;
   int          checked;

   function new();
      restart();
      foreach (line_rgb[i]) line_rgb[i] = '0;
      errors = 0;
      checked = 0;
   endfunction

   function void restart();
      hdr_count = 0;
      foreach (hdr_word[i]) hdr_word[i] = '0;
      col_pos = 0;
      plane = rpd_pkg::PLANE_RED;
      row_pos = 0;
      run_pend = 1'b0;
      run_len = '0;
      done = 1'b0;
   endfunction

   function int line_width();
      int w;
      w = int'(hdr_word[2]) - int'(hdr_word[0]) + 1;
      if (w > STORE_DEPTH) w = STORE_DEPTH;
      return w;
   endfunction

   function int line_count();
      return int'(hdr_word[3]) - int'(hdr_word[1]) + 1;
   endfunction

   function void paint_run(logic [7:0] v, int unsigned len);
      int w;
      int h;
      int unsigned i;
      logic [23:0] e;
      rpd_pkg::pix_type p;
      w = line_width();
      h = line_count();
      if (w <= 0 || h <= 0) begin
         done = 1'b1;
         return;
      end
      for (i = 0; i < len && col_pos < w; i++) begin
         case (plane)
            rpd_pkg::PLANE_RED: begin
               line_rgb[col_pos][23:16] = v;
            end
            rpd_pkg::PLANE_GREEN: begin
               line_rgb[col_pos][15:8] = v;
            end
            rpd_pkg::PLANE_BLUE: begin
               line_rgb[col_pos][7:0] = v;
            end
            default: begin
               e = line_rgb[col_pos];
               p.red = e[23:16];
               p.green = e[15:8];
               p.blue = e[7:0];
               p.pixel_column = col_pos[9:0];
               p.pixel_row = row_pos[15:0];
               p.run_last = (i + 1 == len) || (col_pos + 1 >= w);
               pending_pixels.push_back(p);
            end
         endcase
         col_pos++;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         if (plane == rpd_pkg::PLANE_LAST) begin
            plane = rpd_pkg::PLANE_RED;
            row_pos++;
            if (row_pos >= h) done = 1'b1;
         end else begin
            plane = plane + 2'd1;
         end
      end
   endfunction

   function void note_byte(logic [7:0] b, bit sof);
      int unsigned k;
      logic [5:0] len;
      if (sof) restart();
      if (hdr_count < rpd_pkg::HEADER_LEN) begin
         if (hdr_count >= rpd_pkg::HDR_XMIN_LO && hdr_count <= rpd_pkg::HDR_YMAX_HI) begin
            k = (hdr_count - rpd_pkg::HDR_XMIN_LO) >> 1;
            if (hdr_count[0]) hdr_word[k][15:8] = b;
            else hdr_word[k][7:0] = b;
         end
         hdr_count++;
         if (hdr_count == rpd_pkg::HEADER_LEN && (line_width() <= 0 || line_count() <= 0))
            done = 1'b1;
      end else if (!done) begin
         if (run_pend) begin
            len = run_len;
            run_pend = 1'b0;
            run_len = '0;
            paint_run(b, len);
         end else if (b[7:6] == rpd_pkg::RUN_MARK) begin
            run_pend = 1'b1;
            run_len = b[5:0];
         end else begin
            paint_run(b, 1);
         end
      end
   endfunction

   task report_mismatch(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   task check_pixel(rpd_pkg::pix_type got);
      rpd_pkg::pix_type want;
      if (pending_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected word col %0d row %0d",
                                   got.pixel_column, got.pixel_row));
         return;
      end
      want = pending_pixels.pop_front();
      checked++;
      if (got.red !== want.red)
         report_mismatch($sformatf("red col %0d row %0d got %h want %h",
                         want.pixel_column, want.pixel_row, got.red, want.red));
      if (got.green !== want.green)
         report_mismatch($sformatf("green col %0d row %0d got %h want %h",
                         want.pixel_column, want.pixel_row, got.green, want.green));
      if (got.blue !== want.blue)
         report_mismatch($sformatf("blue col %0d row %0d got %h want %h",
                         want.pixel_column, want.pixel_row, got.blue, want.blue));
      if (got.pixel_column !== want.pixel_column)
         report_mismatch($sformatf("column got %0d want %0d",
                         got.pixel_column, want.pixel_column));
      if (got.pixel_row !== want.pixel_row)
         report_mismatch($sformatf("row got %0d want %0d", got.pixel_row, want.pixel_row));
      if (got.run_last !== want.run_last)
         report_mismatch($sformatf("run_last col %0d row %0d got %b want %b",
                         want.pixel_column, want.pixel_row, got.run_last, want.run_last));
   endtask
endclass

module pcx_rle_planar_rgb_decoder_core_test;
   localparam int MAX_WIDTH = 1024;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_start_of_file = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [9:0]  rsp_pixel_column;
   logic [15:0] rsp_pixel_row;
   logic        rsp_run_last;

   pcx_pixel_scoreboard sb;
   int send_idle = 0;
   int recv_idle = 0;
   int files_sent = 0;
   int bytes_sent = 0;

   always #4 clock = ~clock;

   pcx_rle_planar_rgb_decoder_core #(
      .MAX_WIDTH(MAX_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data_byte(req_data_byte),
      .req_start_of_file(req_start_of_file),
      .empty(empty),
      .pop(pop),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue),
      .rsp_pixel_column(rsp_pixel_column),
      .rsp_pixel_row(rsp_pixel_row),
      .rsp_run_last(rsp_run_last)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty)
            sb.check_pixel({rsp_red, rsp_green, rsp_blue, rsp_pixel_column,
                            rsp_pixel_row, rsp_run_last});
         pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic push_byte(input logic [7:0] b, input bit sof);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= b;
      req_start_of_file <= sof;
      do @(posedge clock); while (full);
      sb.note_byte(b, sof);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [15:0] xmin, input logic [15:0] ymin,
                              input logic [15:0] xmax, input logic [15:0] ymax);
      int i;
      logic [7:0] b;
      for (i = 0; i < rpd_pkg::HEADER_LEN; i++) begin
         case (i)
            0:  b = 8'h0a;
            4:  b = xmin[7:0];
            5:  b = xmin[15:8];
            6:  b = ymin[7:0];
            7:  b = ymin[15:8];
            8:  b = xmax[7:0];
            9:  b = xmax[15:8];
            10: b = ymax[7:0];
            11: b = ymax[15:8];
            default: b = 8'($urandom_range(255));
         endcase
         push_byte(b, i == 0);
      end
      files_sent++;
   endtask

   initial begin
      sb = new();
      send_idle = 36;
      recv_idle = 70;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // 40x1 image: zero run, clipped runs, a literal, marker-valued pixels
      send_header(16'd3, 16'd7, 16'd42, 16'd7);
      push_byte(8'hc0, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'ha1, 1'b0);
      push_byte(8'hc5, 1'b0);
      push_byte(8'hb2, 1'b0);
      push_byte(8'h3c, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h7e, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'hc9, 1'b0);
      push_byte(8'hd9, 1'b0);
      push_byte(8'h0f, 1'b0);

      send_idle = 70;
      recv_idle = 36;
      push_byte(8'hc8, 1'b0);
      push_byte(8'he4, 1'b0);

      send_idle = 0;
      recv_idle = 0;
      push_byte(8'hff, 1'b0);
      push_byte(8'h41, 1'b0);
      // trailing bytes after the last line
      push_byte(8'hc3, 1'b0);
      push_byte(8'h05, 1'b0);
      push <= 1'b0;

      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      $display("decoded %0d files from %0d bytes, %0d pixel words checked",
               files_sent, bytes_sent, sb.checked);
      $display("covered zero, clipped and literal runs, long plane-3 runs, trailing bytes");
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### pcx_rle_planar_rgb_decoder_core.f
rtl/rpd_pkg.sv
rtl/rpd_ram.sv
rtl/rpd_fifo.sv
rtl/rpd_front.sv
rtl/rpd_back.sv
rtl/pcx_rle_planar_rgb_decoder_core.sv
sim/pcx_rle_planar_rgb_decoder_core_test.sv
